FILE: hw/rtl/kwm_pkg.sv
// shared types and constants for the k-way timestamp merge unit
package kwm_pkg;

	localparam int STREAM_W    = 3;
	localparam int TSTAMP_W    = 64;
	localparam int TREE_LEAVES = 8;
	localparam int CNT_W       = 4;
	localparam int MASK_W      = 8;

	localparam logic REG_STREAM_COUNT  = 1'b0;
	localparam logic REG_STREAM_ENABLE = 1'b1;

	localparam logic FUNC_NEXT = 1'b0;
	localparam logic FUNC_END  = 1'b1;

	typedef enum logic [1:0] {
		ST_PENDING   = 2'd0,
		ST_VALID     = 2'd1,
		ST_EXHAUSTED = 2'd2
	} head_st_t;

	// refill or end-of-stream write into one head
	typedef struct packed {
		logic                en;
		logic                exhaust;
		logic [STREAM_W-1:0] idx;
		logic [TSTAMP_W-1:0] tstamp;
	} head_wr_t;

	// head handed out as winner goes back to pending
	typedef struct packed {
		logic                en;
		logic [STREAM_W-1:0] idx;
	} head_pick_t;

	typedef struct packed {
		logic                vld;
		logic [STREAM_W-1:0] id;
		logic [TSTAMP_W-1:0] tstamp;
	} cand_t;

endpackage

FILE: hw/rtl/k_way_timestamp_merge_unit.sv
// k-way timestamp merge: top level with input register, control and result register
// Takes one word per cycle unless the output stalls, and answers each with at most one
// result: the id of the stream whose head is now smallest, or a done flag once every
// stream in use is exhausted. A word waits in the input register, where it is merged into
// the head table and the minimum is found in the same cycle; the result register then
// takes its result, though an output stall can hold the word back first. The cycle time
// is set by the refill mux plus a three-level compare tree over up to eight 64-bit heads.
// Head times are not cleared after reset: a head is only read after its stream has
// written it. A winner is only given when no stream in use waits for a refill, so the
// source is expected to send the winner's next timestamp (or its end) after each result.
module k_way_timestamp_merge_unit #(
	parameter int MAX_STREAMS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // stream[2:0], timestamp[66:3], zero pad
	input  logic [0:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // winner[2:0], zero pad
	output logic [0:0]  m_tuser,   // done_res
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int NUM_HEADS = (MAX_STREAMS < kwm_pkg::TREE_LEAVES) ?
		MAX_STREAMS : kwm_pkg::TREE_LEAVES;

	logic [kwm_pkg::CNT_W-1:0]    cnt_q;
	logic [kwm_pkg::MASK_W-1:0]   ena_q;
	logic                         finished_q;

	logic                         vld_s1;
	logic                         func_s1;
	logic [kwm_pkg::STREAM_W-1:0] stream_s1;
	logic [kwm_pkg::TSTAMP_W-1:0] tstamp_s1;

	logic                         out_vld_q;
	logic [kwm_pkg::STREAM_W-1:0] winner_q;
	logic                         done_q;

	logic                         proc;
	logic                         in_use   [NUM_HEADS];
	logic                         cand_vld [NUM_HEADS];
	kwm_pkg::head_st_t            view_st  [NUM_HEADS];
	logic [kwm_pkg::TSTAMP_W-1:0] view_tm  [NUM_HEADS];
	kwm_pkg::head_wr_t            wr;
	kwm_pkg::head_pick_t          pick;
	logic                         any_pending;
	logic                         have;
	logic [kwm_pkg::STREAM_W-1:0] best;
	logic                         emit;

	assign cfg_ready = 1'b1;
	assign proc      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready  = !vld_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= kwm_pkg::CNT_W'(8);
			ena_q <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				kwm_pkg::REG_STREAM_COUNT:  cnt_q <= cfg_data[kwm_pkg::CNT_W-1:0];
				kwm_pkg::REG_STREAM_ENABLE: ena_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1   <= s_tuser[0];
			stream_s1 <= s_tdata[2:0];
			tstamp_s1 <= s_tdata[66:3];
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_HEADS; i++) begin
			in_use[i] = (kwm_pkg::CNT_W'(i) < cnt_q) && ena_q[i];
		end
	end

	// refill request for a stream in use; the heads block drops it unless that head is pending
	always_comb begin
		wr.en     = 1'b0;
		wr.exhaust = (func_s1 == kwm_pkg::FUNC_END);
		wr.idx    = stream_s1;
		wr.tstamp = tstamp_s1;
		for (int i = 0; i < NUM_HEADS; i++) begin
			if (stream_s1 == kwm_pkg::STREAM_W'(i) && in_use[i] && !finished_q) begin
				wr.en = 1'b1;
			end
		end
	end

	kwm_heads #(
		.NUM_HEADS(NUM_HEADS)
	) u_heads (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wr_commit(proc),
		.pick     (pick),
		.view_st  (view_st),
		.view_tm  (view_tm)
	);

	always_comb begin
		any_pending = 1'b0;
		for (int i = 0; i < NUM_HEADS; i++) begin
			cand_vld[i] = in_use[i] && view_st[i] == kwm_pkg::ST_VALID;
			if (in_use[i] && view_st[i] == kwm_pkg::ST_PENDING) begin
				any_pending = 1'b1;
			end
		end
	end

	kwm_min_tree #(
		.NUM_HEADS(NUM_HEADS)
	) u_tree (
		.cand_vld(cand_vld),
		.cand_tm (view_tm),
		.have    (have),
		.best    (best)
	);

	assign emit     = !finished_q && !any_pending;
	assign pick.en  = emit && have;
	assign pick.idx = best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finished_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (proc) begin
				out_vld_q <= emit;
				if (emit && !have) begin
					finished_q <= 1'b1;
				end
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			winner_q <= have ? best : '0;
			done_q   <= !have;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'b0, winner_q};
	assign m_tuser  = done_q;

endmodule

FILE: hw/rtl/kwm_heads.sv
// per-stream head timestamps and status, with the current write folded into the view
module kwm_heads #(
	parameter int NUM_HEADS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  kwm_pkg::head_wr_t                   wr,
	input  logic                                wr_commit,
	input  kwm_pkg::head_pick_t                 pick,
	output kwm_pkg::head_st_t                   view_st [NUM_HEADS],
	output logic [kwm_pkg::TSTAMP_W-1:0]        view_tm [NUM_HEADS]
);

	kwm_pkg::head_st_t                  st_q [NUM_HEADS];
	logic [kwm_pkg::TSTAMP_W-1:0]       tm_q [NUM_HEADS];

	// status and time as they stand once this word's refill is applied
	// a refill only lands on a head that is waiting for one
	always_comb begin
		for (int i = 0; i < NUM_HEADS; i++) begin
			view_st[i] = st_q[i];
			view_tm[i] = tm_q[i];
			if (wr.en && wr.idx == kwm_pkg::STREAM_W'(i) &&
					st_q[i] == kwm_pkg::ST_PENDING) begin
				view_st[i] = wr.exhaust ? kwm_pkg::ST_EXHAUSTED : kwm_pkg::ST_VALID;
				if (!wr.exhaust) begin
					view_tm[i] = wr.tstamp;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_HEADS; i++) begin
				st_q[i] <= kwm_pkg::ST_PENDING;
			end
		end else if (wr_commit) begin
			for (int i = 0; i < NUM_HEADS; i++) begin
				if (pick.en && pick.idx == kwm_pkg::STREAM_W'(i)) begin
					st_q[i] <= kwm_pkg::ST_PENDING;
				end else begin
					st_q[i] <= view_st[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_commit) begin
			for (int i = 0; i < NUM_HEADS; i++) begin
				tm_q[i] <= view_tm[i];
			end
		end
	end

endmodule

FILE: hw/rtl/kwm_min_tree.sv
// three-level compare tree picking the smallest valid head, lower id on ties
module kwm_min_tree #(
	parameter int NUM_HEADS = 8
) (
	input  logic                          cand_vld [NUM_HEADS],
	input  logic [kwm_pkg::TSTAMP_W-1:0]  cand_tm  [NUM_HEADS],
	output logic                          have,
	output logic [kwm_pkg::STREAM_W-1:0]  best
);

	kwm_pkg::cand_t leaf [kwm_pkg::TREE_LEAVES];
	kwm_pkg::cand_t lvl1 [kwm_pkg::TREE_LEAVES/2];
	kwm_pkg::cand_t lvl2 [kwm_pkg::TREE_LEAVES/4];
	kwm_pkg::cand_t root;

	function automatic kwm_pkg::cand_t pick_min(kwm_pkg::cand_t lo, kwm_pkg::cand_t hi);
		// lo always carries the lower ids, so it wins a tie
		if (lo.vld && (!hi.vld || lo.tstamp <= hi.tstamp)) begin
			return lo;
		end
		return hi;
	endfunction

	always_comb begin
		for (int i = 0; i < kwm_pkg::TREE_LEAVES; i++) begin
			leaf[i] = '{vld: 1'b0, id: kwm_pkg::STREAM_W'(i), tstamp: '0};
		end
		for (int i = 0; i < NUM_HEADS; i++) begin
			leaf[i].vld    = cand_vld[i];
			leaf[i].tstamp = cand_tm[i];
		end
		for (int i = 0; i < kwm_pkg::TREE_LEAVES/2; i++) begin
			lvl1[i] = pick_min(leaf[2*i], leaf[2*i+1]);
		end
		for (int i = 0; i < kwm_pkg::TREE_LEAVES/4; i++) begin
			lvl2[i] = pick_min(lvl1[2*i], lvl1[2*i+1]);
		end
		root = pick_min(lvl2[0], lvl2[1]);
		have = root.vld;
		best = root.id;
	end

endmodule

FILE: hw/rtl/kwm_checker.sv
// port-level checks for the k-way timestamp merge unit, bound to the top level
module kwm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [0:0]  m_tuser
);

	// nothing follows the done word
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser[0] |=> !m_tvalid)
		else $error("result after done word");

	a_done_winner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[2:0] == 3'd0)
		else $error("done word carries a winner");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:3] == 5'd0)
		else $error("output pad bits not zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind k_way_timestamp_merge_unit kwm_checker u_kwm_checker (.*);
